FILE: hdl/line_framer_with_command_queue_unit_macros.svh
// Assertion macros shared by the line framer checker.
`ifndef LINE_FRAMER_WITH_COMMAND_QUEUE_UNIT_MACROS_SVH
`define LINE_FRAMER_WITH_COMMAND_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LFCQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define LFCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lfcq_pkg.sv
// Shared types and constants of the line framer with command queue.
package lfcq_pkg;

  localparam logic [1:0] CMD_RX   = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_DISC = 2'd2;
  localparam logic [1:0] CMD_FLAG = 2'd3;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [7:0] CAP_RESET = 8'd240;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic        read_valid;
    logic [7:0]  read_char;
    logic        line_end;
    logic        line_queued;
    logic        line_lost;
    logic        overlong;
    logic        disconnect_flag;
    logic [3:0]  queue_count;
    logic [31:0] lines_accepted;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;       // execute a beat that needs no memory read
    logic rd_issue;   // start the character and length read of the head line
    logic rd_finish;  // complete a read beat from the registered read data
    logic load_out;   // capture the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_needed;  // the offered beat is a read of a non-empty queue
  } dp_sts_t;

endpackage

FILE: hdl/lfcq_dp.sv
// Datapath of the line framer: assembler state, line store, queue pointers, result register.
module lfcq_dp #(
  parameter int LINE_CHARS  = 240,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lfcq_pkg::in_beat_t  in_data,
  input  logic                cfg_wr,
  input  logic [7:0]          cfg_data,
  input  lfcq_pkg::dp_cmd_t   cmd,
  output lfcq_pkg::dp_sts_t   sts,
  output lfcq_pkg::out_beat_t out_data
);

  // One spare slot: the line being assembled always has a slot of its own.
  localparam int NS = QUEUE_DEPTH + 1;
  localparam int SW = $clog2(NS);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = $clog2(LINE_CHARS);
  localparam int AW = SW + PW;
  localparam int MD = NS * (2 ** PW);

  logic [7:0]  cap_r;
  logic [7:0]  alen_r, alen_nxt;
  logic [7:0]  tlen_r, tlen_nxt;
  logic        zseen_r, zseen_nxt;
  logic        disc_r, disc_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]  rpos_r, rpos_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] total_r, total_nxt;
  logic [7:0]  rd_char_r;
  logic [7:0]  rd_len_r;
  lfcq_pkg::out_beat_t out_r;
  lfcq_pkg::out_beat_t res;

  logic [7:0] char_mem [0:MD-1];
  logic [7:0] len_mem  [0:NS-1];

  logic [SW:0]   tail_sum;
  logic [SW-1:0] tail;
  logic          cw_en;
  logic          lw_en;
  logic          is_term;
  logic [7:0]    cap_eff;
  logic [7:0]    cap_m1;
  logic [7:0]    limit;

  assign tail_sum = {1'b0, head_r} + (SW+1)'(fill_r);
  assign tail     = (tail_sum >= (SW+1)'(NS)) ? SW'(tail_sum - (SW+1)'(NS)) : SW'(tail_sum);
  assign is_term  = (in_data.rx_byte == lfcq_pkg::CH_LF) ||
                    (in_data.rx_byte == lfcq_pkg::CH_CR);
  assign cap_eff  = (cap_r == 8'd0) ? 8'd1 : cap_r;
  assign cap_m1   = cap_eff - 8'd1;
  assign limit    = (rd_len_r > cap_m1) ? cap_m1 : rd_len_r;

  assign sts.rd_needed = (in_data.command == lfcq_pkg::CMD_READ) && (fill_r != '0);

  always_comb begin
    alen_nxt  = alen_r;
    tlen_nxt  = tlen_r;
    zseen_nxt = zseen_r;
    disc_nxt  = disc_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    rpos_nxt  = rpos_r;
    pend_nxt  = pend_r;
    total_nxt = total_r;
    cw_en     = 1'b0;
    lw_en     = 1'b0;
    res       = '0;

    if (cmd.exec) begin
      case (in_data.command)
        lfcq_pkg::CMD_RX: begin
          if (is_term) begin
            if (!disc_r && (alen_r != 8'd0)) begin
              if (fill_r < FW'(QUEUE_DEPTH)) begin
                lw_en           = 1'b1;
                fill_nxt        = fill_r + FW'(1);
                total_nxt       = total_r + 32'd1;
                res.line_queued = 1'b1;
              end else begin
                res.line_lost = 1'b1;
              end
            end
            alen_nxt  = 8'd0;
            tlen_nxt  = 8'd0;
            zseen_nxt = 1'b0;
            disc_nxt  = 1'b0;
          end else if (!disc_r) begin
            if (({1'b0, alen_r} + 9'd1) < 9'(LINE_CHARS)) begin
              cw_en    = 1'b1;
              alen_nxt = alen_r + 8'd1;
              if (!zseen_r) begin
                if (in_data.rx_byte == 8'd0) begin
                  zseen_nxt = 1'b1;
                end else begin
                  tlen_nxt = tlen_r + 8'd1;
                end
              end
            end else begin
              alen_nxt     = 8'd0;
              tlen_nxt     = 8'd0;
              zseen_nxt    = 1'b0;
              disc_nxt     = 1'b1;
              res.overlong = 1'b1;
            end
          end
        end
        lfcq_pkg::CMD_READ: begin
          // Only an empty queue reaches here; the result holds only the queue count and line total.
        end
        lfcq_pkg::CMD_DISC: begin
          alen_nxt  = 8'd0;
          tlen_nxt  = 8'd0;
          zseen_nxt = 1'b0;
          disc_nxt  = 1'b0;
          head_nxt  = '0;
          fill_nxt  = '0;
          rpos_nxt  = 8'd0;
          pend_nxt  = 1'b1;
        end
        lfcq_pkg::CMD_FLAG: begin
          res.disconnect_flag = pend_r;
          pend_nxt            = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.rd_finish) begin
      res.read_valid = 1'b1;
      if (rpos_r < limit) begin
        res.read_char = rd_char_r;
        rpos_nxt      = rpos_r + 8'd1;
      end else begin
        res.line_end = 1'b1;
        head_nxt     = (head_r == SW'(NS - 1)) ? '0 : head_r + SW'(1);
        fill_nxt     = fill_r - FW'(1);
        rpos_nxt     = 8'd0;
      end
    end

    res.queue_count    = 4'(fill_nxt);
    res.lines_accepted = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= lfcq_pkg::CAP_RESET;
      alen_r  <= 8'd0;
      tlen_r  <= 8'd0;
      zseen_r <= 1'b0;
      disc_r  <= 1'b0;
      head_r  <= '0;
      fill_r  <= '0;
      rpos_r  <= 8'd0;
      pend_r  <= 1'b0;
      total_r <= 32'd0;
    end else begin
      if (cfg_wr) begin
        cap_r <= cfg_data;
      end
      alen_r  <= alen_nxt;
      tlen_r  <= tlen_nxt;
      zseen_r <= zseen_nxt;
      disc_r  <= disc_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      rpos_r  <= rpos_nxt;
      pend_r  <= pend_nxt;
      total_r <= total_nxt;
    end
  end

  // Character store: one row per slot, written at the tail, read at the head.
  always_ff @(posedge clk) begin
    if (cw_en) begin
      char_mem[AW'({tail, alen_r[PW-1:0]})] <= in_data.rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_char_r <= char_mem[AW'({head_r, rpos_r[PW-1:0]})];
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      len_mem[tail] <= tlen_r;
    end
    if (cmd.rd_issue) begin
      rd_len_r <= len_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/lfcq_ctrl.sv
// Controller of the line framer: beat acceptance, read sequencing and output valid.
module lfcq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lfcq_pkg::dp_sts_t sts,
  output lfcq_pkg::dp_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          if (sts.rd_needed) begin
            cmd.rd_issue = 1'b1;
            state_nxt    = ST_READ;
          end else begin
            cmd.exec     = 1'b1;
            cmd.load_out = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd.rd_finish = 1'b1;
          cmd.load_out  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/line_framer_with_command_queue_unit.sv
// Top level of the line framer with command queue: controller plus datapath.
// The block assembles received bytes into lines ended by CR or LF, queues up
// to QUEUE_DEPTH finished lines, and hands them back one character per read
// beat followed by a zero terminator that pops the line. Every input beat
// produces exactly one result beat. Byte, disconnect and flag beats, and reads
// of an empty queue, are executed as they are accepted; a read of a queued
// line first reads the character store and the slot length store, memories
// with registered read data, and then forms its result from that data while
// new beats wait. A full output register held by out_stall holds off
// new input beats until the result is taken. Each line is written straight
// into its queue slot as it arrives; the store keeps one spare slot so the
// line under assembly never overwrites the line being read, which means no
// copy is needed when a line is committed. The character store holds
// (QUEUE_DEPTH+1) rows of 2**ceil(log2(LINE_CHARS)) bytes. The read_capacity
// register (reset 240) limits a returned line to read_capacity-1 characters,
// with zero treated as one; it is written through the cfg_ port, which is
// always ready, and should only be changed while the block is idle.
module line_framer_with_command_queue_unit #(
  parameter int LINE_CHARS  = 240,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input beats: command and received byte.
  input  logic                in_valid,
  output logic                in_stall,
  input  lfcq_pkg::in_beat_t  in_data,
  // Result beats.
  output logic                out_valid,
  input  logic                out_stall,
  output lfcq_pkg::out_beat_t out_data,
  // Configuration write of read_capacity.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  lfcq_pkg::dp_cmd_t dp_cmd;
  lfcq_pkg::dp_sts_t dp_sts;

  // The register write never has to wait.
  assign cfg_ready = 1'b1;

  lfcq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  lfcq_dp #(
    .LINE_CHARS  (LINE_CHARS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (dp_cmd),
    .sts      (dp_sts),
    .out_data (out_data)
  );

endmodule

FILE: hdl/lfcq_chk.sv
// Port-level checker of the line framer and its bind to the top level.
`include "line_framer_with_command_queue_unit_macros.svh"

module lfcq_chk #(
  parameter int QUEUE_DEPTH = 8
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lfcq_pkg::out_beat_t out_data
);

  `LFCQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed while stalled")
  `LFCQ_ASSERT_NOW(a_end_is_zero, out_valid && out_data.line_end, out_data.read_valid && (out_data.read_char == 8'd0), "line end without a valid zero terminator")
  `LFCQ_ASSERT_NOW(a_kind_excl, out_valid && out_data.read_valid, !(out_data.line_queued || out_data.line_lost || out_data.overlong || out_data.disconnect_flag), "read result mixed with byte or flag result")
  `LFCQ_ASSERT_NOW(a_count_max, out_valid, {28'd0, out_data.queue_count} <= 32'(QUEUE_DEPTH), "queue count above queue depth")

endmodule

bind line_framer_with_command_queue_unit lfcq_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_lfcq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: dv/line_framer_with_command_queue_unit_tb.sv
// Self-checking testbench for the line framer with command queue unit.
`timescale 1ns / 1ps

module line_framer_with_command_queue_unit_tb;

  localparam int LINE_MAX = 240;
  localparam int SLOTS = 8;
  localparam int RANDOM_BEATS = 120;
  localparam int NUM_PHASES = 6;
  // Settling time after the last result, covering a read of a queued line and the output register.
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS = 10;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  lfcq_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lfcq_pkg::out_beat_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data = 8'd0;

  line_framer_with_command_queue_unit #(
    .LINE_CHARS (LINE_MAX),
    .QUEUE_DEPTH(SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the framer and queue state, advanced once per accepted beat.
  logic [7:0]  cap_reg;
  logic [7:0]  asm_chars [LINE_MAX];
  logic [7:0]  asm_len;
  logic [7:0]  text_len;
  bit          zero_seen;
  bit          discarding;
  logic [7:0]  slot_chars [SLOTS][LINE_MAX];
  logic [7:0]  slot_len [SLOTS];
  logic [2:0]  head;
  logic [3:0]  fill;
  logic [7:0]  rd_pos;
  bit          disc_pending;
  logic [31:0] accepted_total;

  lfcq_pkg::out_beat_t results_due [$];
  int        fail_count = 0;
  int        beats_sent = 0;
  int        results_seen = 0;
  bit        calm = 1'b0;
  int        stall_left = 0;

  // One row of the directed table. When typed is set, want is the result read
  // straight off the spec; otherwise the framer model supplies it.
  typedef struct packed {
    lfcq_pkg::in_beat_t  beat;
    bit                  typed;
    lfcq_pkg::out_beat_t want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  function automatic void clear_line_state();
    asm_len    = '0;
    text_len   = '0;
    zero_seen  = 1'b0;
    discarding = 1'b0;
  endfunction

  // Computes the result of one beat and moves the shadow state along.
  function automatic lfcq_pkg::out_beat_t framer_step(lfcq_pkg::in_beat_t b);
    lfcq_pkg::out_beat_t r;
    logic [2:0]          slot;
    int                  cap;
    int                  lim;
    r = '0;
    case (b.command)
      lfcq_pkg::CMD_RX: begin
        if (b.rx_byte == lfcq_pkg::CH_LF || b.rx_byte == lfcq_pkg::CH_CR) begin
          // Empty lines and lines being discarded never reach the queue.
          if (!discarding && asm_len != 8'd0) begin
            if (int'(fill) < SLOTS) begin
              slot = head + fill[2:0];
              for (int i = 0; i < LINE_MAX; i++) begin
                if (i < int'(text_len)) slot_chars[slot][i] = asm_chars[i];
              end
              slot_len[slot] = text_len;
              fill++;
              accepted_total++;
              r.line_queued = 1'b1;
            end else begin
              r.line_lost = 1'b1;
            end
          end
          clear_line_state();
        end else if (discarding) begin
          // Everything up to the next terminator is dropped.
        end else if (int'(asm_len) + 1 < LINE_MAX) begin
          asm_chars[asm_len] = b.rx_byte;
          asm_len++;
          // A zero byte counts toward the length but ends the stored text.
          if (!zero_seen) begin
            if (b.rx_byte == 8'h00) zero_seen = 1'b1;
            else text_len++;
          end
        end else begin
          clear_line_state();
          discarding = 1'b1;
          r.overlong = 1'b1;
        end
      end
      lfcq_pkg::CMD_READ: begin
        if (fill != 4'd0) begin
          // A capacity of zero behaves as one, so only the terminator comes back.
          cap = (cap_reg == 8'd0) ? 1 : int'(cap_reg);
          lim = int'(slot_len[head]);
          if (lim > cap - 1) lim = cap - 1;
          r.read_valid = 1'b1;
          if (int'(rd_pos) < lim) begin
            r.read_char = slot_chars[head][rd_pos];
            rd_pos++;
          end else begin
            r.line_end = 1'b1;
            head++;
            fill--;
            rd_pos = '0;
          end
        end
      end
      lfcq_pkg::CMD_DISC: begin
        clear_line_state();
        head         = '0;
        fill         = '0;
        rd_pos       = '0;
        disc_pending = 1'b1;
      end
      lfcq_pkg::CMD_FLAG: begin
        r.disconnect_flag = disc_pending;
        disc_pending      = 1'b0;
      end
      default: ;
    endcase
    r.queue_count    = fill;
    r.lines_accepted = accepted_total;
    return r;
  endfunction

  function automatic lfcq_pkg::out_beat_t typed_result(int v, int c, int e, int q, int l,
                                                       int o, int f, int n, int a);
    lfcq_pkg::out_beat_t r;
    r.read_valid      = 1'(v);
    r.read_char       = 8'(c);
    r.line_end        = 1'(e);
    r.line_queued     = 1'(q);
    r.line_lost       = 1'(l);
    r.overlong        = 1'(o);
    r.disconnect_flag = 1'(f);
    r.queue_count     = 4'(n);
    r.lines_accepted  = 32'(a);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] cmd, logic [7:0] byt, bit typed,
                                  lfcq_pkg::out_beat_t want);
    stim_row_t row;
    row.beat.command = cmd;
    row.beat.rx_byte = byt;
    row.typed        = typed;
    row.want         = want;
    directed_rows.push_back(row);
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic lfcq_pkg::in_beat_t random_beat();
    lfcq_pkg::in_beat_t b;
    b.command = 2'($urandom_range(0, 3));
    b.rx_byte = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      note_failure($sformatf("result %0d %s: expected %0h, got %0h",
                             results_seen, name, want, got));
    end
  endfunction

  // All driving tasks start and end at a falling edge. A beat stays offered
  // until an edge finds in_stall low; only then does the model advance.
  task automatic send_beat(lfcq_pkg::in_beat_t beat, bit typed, lfcq_pkg::out_beat_t want);
    lfcq_pkg::out_beat_t predicted;
    int                  gap;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    predicted = framer_step(beat);
    results_due.push_back(typed ? want : predicted);
    beats_sent++;
    gap = gap_len();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_data  <= random_beat();
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [7:0] byt);
    lfcq_pkg::in_beat_t b;
    b.command = cmd;
    b.rx_byte = byt;
    send_beat(b, 1'b0, '0);
  endtask

  // Sends len characters and a CR or LF. Zero bytes are sprinkled in when allowed.
  task automatic send_line(int len, bit allow_zero);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      if (allow_zero && $urandom_range(0, 15) == 0) begin
        c = 8'h00;
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (c == lfcq_pkg::CH_LF || c == lfcq_pkg::CH_CR);
      end
      send_cmd(lfcq_pkg::CMD_RX, c);
    end
    send_cmd(lfcq_pkg::CMD_RX,
             ($urandom_range(0, 1) == 1) ? lfcq_pkg::CH_CR : lfcq_pkg::CH_LF);
  endtask

  // Holds off the sender until every result is in, then lets the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Reads until the head line pops, sometimes stopping partway through; on an empty queue it sends one or two reads.
  task automatic read_burst();
    int cap;
    int lim;
    int n;
    if (fill == 4'd0) begin
      n = $urandom_range(1, 2);
    end else begin
      cap = (cap_reg == 8'd0) ? 1 : int'(cap_reg);
      lim = int'(slot_len[head]);
      if (lim > cap - 1) lim = cap - 1;
      n = lim - int'(rd_pos) + 1;
      if (n < 1) n = 1;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
    end
    repeat (n) send_cmd(lfcq_pkg::CMD_READ, 8'($urandom_range(0, 255)));
  endtask

  // Most sequences are well-formed lines and reads; the rest floods the
  // queue, disconnects, polls the flag, or sends arbitrary beats.
  task automatic random_sequence();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      len = $urandom_range(0, 99);
      if (len < 8) len = 0;
      else if (len < 10) len = $urandom_range(236, 244);
      else len = $urandom_range(1, 12);
      send_line(len, 1'b1);
    end else if (pick < 75) begin
      read_burst();
    end else if (pick < 80) begin
      repeat ($urandom_range(9, 11)) send_line($urandom_range(1, 4), 1'b1);
    end else if (pick < 85) begin
      send_cmd(lfcq_pkg::CMD_DISC, 8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      send_cmd(lfcq_pkg::CMD_FLAG, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) send_beat(random_beat(), 1'b0, '0);
    end
  endtask

  // The receiver stalls in bursts of random length, except in calm stretches.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  // Every result beat taken is compared with the oldest expectation.
  lfcq_pkg::out_beat_t oldest_due;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        note_failure($sformatf("result %0d arrived with nothing expected: %p",
                               results_seen, out_data));
      end else begin
        oldest_due = results_due.pop_front();
        check_field("read_valid", 32'(oldest_due.read_valid), 32'(out_data.read_valid));
        check_field("read_char", 32'(oldest_due.read_char), 32'(out_data.read_char));
        check_field("line_end", 32'(oldest_due.line_end), 32'(out_data.line_end));
        check_field("line_queued", 32'(oldest_due.line_queued),
                    32'(out_data.line_queued));
        check_field("line_lost", 32'(oldest_due.line_lost), 32'(out_data.line_lost));
        check_field("overlong", 32'(oldest_due.overlong), 32'(out_data.overlong));
        check_field("disconnect_flag", 32'(oldest_due.disconnect_flag),
                    32'(out_data.disconnect_flag));
        check_field("queue_count", 32'(oldest_due.queue_count),
                    32'(out_data.queue_count));
        check_field("lines_accepted", oldest_due.lines_accepted, out_data.lines_accepted);
      end
      results_seen++;
    end
  end

  // The slowest correct run is well under a tenth of this.
  initial begin
    #15_000_000;
    $display("line_framer_with_command_queue_unit regression: fail");
    $finish;
  end

  initial begin
    logic [7:0] last_cap;
    int         phase_end;

    cap_reg = lfcq_pkg::CAP_RESET;
    clear_line_state();
    head           = '0;
    fill           = '0;
    rd_pos         = '0;
    disc_pending   = 1'b0;
    accepted_total = '0;

    // Directed rows: a partly zero line, an empty line, a zero-only line,
    // reads to the end of both, a read of the empty queue, and a disconnect
    // that wipes a half-built line and sets the flag exactly once.
    add_row(lfcq_pkg::CMD_READ, 8'h00, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(lfcq_pkg::CMD_FLAG, 8'hFF, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(lfcq_pkg::CMD_RX, 8'h41, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(lfcq_pkg::CMD_RX, 8'hFF, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(lfcq_pkg::CMD_RX, 8'h00, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(lfcq_pkg::CMD_RX, 8'h80, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(lfcq_pkg::CMD_RX, lfcq_pkg::CH_LF, 1'b1,
            typed_result(0, 0, 0, 1, 0, 0, 0, 1, 1));
    add_row(lfcq_pkg::CMD_RX, lfcq_pkg::CH_CR, 1'b1,
            typed_result(0, 0, 0, 0, 0, 0, 0, 1, 1));
    add_row(lfcq_pkg::CMD_RX, 8'h00, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 1, 1));
    add_row(lfcq_pkg::CMD_RX, 8'h00, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 1, 1));
    add_row(lfcq_pkg::CMD_RX, lfcq_pkg::CH_CR, 1'b1,
            typed_result(0, 0, 0, 1, 0, 0, 0, 2, 2));
    add_row(lfcq_pkg::CMD_READ, 8'h00, 1'b0, '0);
    add_row(lfcq_pkg::CMD_READ, 8'hFF, 1'b0, '0);
    add_row(lfcq_pkg::CMD_READ, 8'h55, 1'b0, '0);
    add_row(lfcq_pkg::CMD_READ, 8'hAA, 1'b0, '0);
    add_row(lfcq_pkg::CMD_READ, 8'h00, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 0, 2));
    add_row(lfcq_pkg::CMD_RX, 8'h7F, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 0, 2));
    add_row(lfcq_pkg::CMD_DISC, 8'h00, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 0, 2));
    add_row(lfcq_pkg::CMD_RX, lfcq_pkg::CH_LF, 1'b1,
            typed_result(0, 0, 0, 0, 0, 0, 0, 0, 2));
    add_row(lfcq_pkg::CMD_FLAG, 8'h00, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 1, 0, 2));
    add_row(lfcq_pkg::CMD_FLAG, 8'h00, 1'b1, typed_result(0, 0, 0, 0, 0, 0, 0, 0, 2));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end

    // The longest line that fits comes back whole at the reset capacity, and
    // a line of LINE_MAX+5 characters sends the assembler into discard mode.
    send_line(LINE_MAX - 1, 1'b0);
    repeat (LINE_MAX) send_cmd(lfcq_pkg::CMD_READ, 8'h00);
    send_line(LINE_MAX + 5, 1'b0);
    send_cmd(lfcq_pkg::CMD_READ, 8'h00);

    // Capacity drops below the read position partway through a line: the
    // next read has to return the terminator.
    send_line(6, 1'b0);
    repeat (3) send_cmd(lfcq_pkg::CMD_READ, 8'h00);
    drain_results();
    write_capacity(8'd2);
    repeat (2) send_cmd(lfcq_pkg::CMD_READ, 8'h00);
    drain_results();

    // Random phases, each at its own capacity. The sender always waits for
    // every result before the register is touched, and one phase runs with
    // no idling on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: last_cap = 8'd1;
        1: last_cap = 8'd0;
        2: last_cap = 8'd255;
        3: last_cap = 8'd2;
        4: last_cap = 8'($urandom_range(3, 239));
        default: last_cap = lfcq_pkg::CAP_RESET;
      endcase
      write_capacity(last_cap);
      calm = (p == 2);
      phase_end = beats_sent + RANDOM_BEATS / NUM_PHASES;
      while (beats_sent < phase_end) random_sequence();
      drain_results();
    end
    calm = 1'b0;

    if (fail_count == 0) begin
      $display("line_framer_with_command_queue_unit regression: pass");
    end else begin
      $display("line_framer_with_command_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
